/* rtl/core/gdad_pkg.sv */
`default_nettype none

package gdad_pkg;

  // field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned ADD_W   = 15;
  // running day total: up to 366 + 31 + 32767
  localparam int unsigned TOTAL_W = 16;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

  // century arithmetic for the leap rule
  localparam logic [6:0] CENTURY       = 7'd100;
  localparam logic [6:0] CENTURY_LAST  = 7'd99;
  // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned RECIP_SHIFT  = 19;
  localparam int unsigned PROD_W       = YEAR_W + 13;
  // quotient of year / 100 fits in this many bits
  localparam int unsigned QUOT_W       = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREFIX,
    ST_WALK,
    ST_DONE
  } gdad_state_t;

  // control from sequencer to year unit
  typedef struct packed {
    logic start;
    logic inc;
  } gdad_year_ctl_t;

  // status from year unit to sequencer
  typedef struct packed {
    logic busy;
    logic leap;
  } gdad_year_stat_t;

  // month length, months outside 1..12 have no length
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gdad_year_unit.sv */
`default_nettype none

module gdad_year_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gdad_pkg::gdad_year_ctl_t      ctl,
  input  wire logic [gdad_pkg::YEAR_W-1:0]   year_in,
  output      logic [gdad_pkg::YEAR_W-1:0]   year,
  output      gdad_pkg::gdad_year_stat_t     stat
);

  logic [gdad_pkg::YEAR_W-1:0]    year_r, year_nxt;
  logic [gdad_pkg::YEAR_W-1:0]    rem_r, rem_nxt;
  logic [gdad_pkg::QUOT_W-1:0]    quot_r, quot_nxt;
  logic [1:0]                     q4_r, q4_nxt;
  logic                           step_r, step_nxt;
  logic                           busy_r, busy_nxt;
  logic [gdad_pkg::PROD_W-1:0]    prod;

  // reciprocal multiply for year / 100
  assign prod = gdad_pkg::PROD_W'(year_r) * gdad_pkg::PROD_W'(gdad_pkg::RECIP_100);

  always_comb begin
    year_nxt = year_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    q4_nxt   = q4_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      // load year, quotient next cycle, remainder the cycle after
      year_nxt = year_in;
      step_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!step_r) begin
        quot_nxt = prod[gdad_pkg::RECIP_SHIFT +: gdad_pkg::QUOT_W];
        step_nxt = 1'b1;
      end else begin
        rem_nxt  = year_r - gdad_pkg::YEAR_W'(quot_r) * gdad_pkg::YEAR_W'(gdad_pkg::CENTURY);
        q4_nxt   = quot_r[1:0];
        busy_nxt = 1'b0;
      end
    end else if (ctl.inc) begin
      // next year, keep year mod 100 and century mod 4 in step
      if (year_r == gdad_pkg::YEAR_MAX) begin
        year_nxt = '0;
        rem_nxt  = '0;
        q4_nxt   = '0;
      end else begin
        year_nxt = year_r + 1'b1;
        if (rem_r[6:0] == gdad_pkg::CENTURY_LAST) begin
          rem_nxt = '0;
          q4_nxt  = q4_r + 1'b1;
        end else begin
          rem_nxt = rem_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    year_r <= year_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    q4_r   <= q4_nxt;
    step_r <= step_nxt;
  end

  // leap: by 400 at a century, else by 4
  assign year      = year_r;
  assign stat.busy = busy_r;
  assign stat.leap = (rem_r == '0) ? (q4_r == 2'd0) : (year_r[1:0] == 2'd0);

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r)
    else $error("year unit not busy after start");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !ctl.start && step_r) |=> !busy_r)
    else $error("division did not finish after last step");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> rem_r < gdad_pkg::YEAR_W'(gdad_pkg::CENTURY))
    else $error("year remainder not below 100 after division");
`endif

endmodule

`default_nettype wire

/* rtl/core/gregorian_date_add_days_core.sv */
`default_nettype none

// channel   direction  tdata fields (lowest bit up)                     width
// in_       slave      start_year, start_month, start_day, days_to_add   40
// out_      master     result_year, result_month, result_day             24
//
// the time an item takes grows with the months before the start month and
// the months walked, and the month walk through the shared add/subtract
// unit sets most of it, one month per cycle, after the year unit splits
// the year into century and year of century.
// synchronous active-low reset clears the sequencer and the output valid.
// a finished result waits in the output register; a new item is taken
// meanwhile, and the block stalls at its end only if that register is full and not being read.

module gregorian_date_add_days_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[37:23]
  input  wire logic [gdad_pkg::IN_TDATA_W-1:0]    in_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18]
  output      logic [gdad_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  gdad_pkg::gdad_state_t            state_r, state_nxt;
  logic [gdad_pkg::TOTAL_W-1:0]     total_r, total_nxt;
  logic [gdad_pkg::MONTH_W-1:0]     month_r, month_nxt;
  logic [gdad_pkg::MONTH_W-1:0]     smonth_r, smonth_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [gdad_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  gdad_pkg::gdad_year_ctl_t         year_ctl;
  gdad_pkg::gdad_year_stat_t        year_stat;
  logic [gdad_pkg::YEAR_W-1:0]      year;

  logic [gdad_pkg::YEAR_W-1:0]      in_year;
  logic [gdad_pkg::MONTH_W-1:0]     in_month;
  logic [gdad_pkg::DAY_W-1:0]       in_day;
  logic [gdad_pkg::ADD_W-1:0]       in_add;
  logic                             in_xfer;

  logic [gdad_pkg::DAY_W-1:0]       len;
  logic                             alu_sub;
  logic [gdad_pkg::TOTAL_W-1:0]     alu_out;
  logic                             fits_month;

  // input field unpacking
  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_day   = in_tdata[22:18];
  assign in_add   = in_tdata[37:23];

  assign in_tready = (state_r == gdad_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  gdad_year_unit u_year (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (year_ctl),
    .year_in (in_year),
    .year    (year),
    .stat    (year_stat)
  );

  // shared add/subtract unit on the running total
  assign len        = gdad_pkg::month_len(month_r, year_stat.leap);
  assign alu_out    = alu_sub ? total_r - gdad_pkg::TOTAL_W'(len)
                              : total_r + gdad_pkg::TOTAL_W'(len);
  assign fits_month = total_r <= gdad_pkg::TOTAL_W'(len);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    month_nxt     = month_r;
    smonth_nxt    = smonth_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    year_ctl      = '0;
    alu_sub       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      gdad_pkg::ST_IDLE: begin
        if (in_xfer) begin
          total_nxt      = gdad_pkg::TOTAL_W'(in_add) + gdad_pkg::TOTAL_W'(in_day);
          smonth_nxt     = in_month;
          month_nxt      = gdad_pkg::MONTH_JAN;
          year_ctl.start = 1'b1;
          state_nxt      = gdad_pkg::ST_DIV;
        end
      end
      gdad_pkg::ST_DIV: begin
        if (!year_stat.busy) begin
          state_nxt = gdad_pkg::ST_PREFIX;
        end
      end
      gdad_pkg::ST_PREFIX: begin
        // add lengths of the months before the start month
        if (month_r < smonth_r && month_r <= gdad_pkg::MONTH_DEC) begin
          total_nxt = alu_out;
          month_nxt = month_r + 1'b1;
        end else begin
          month_nxt = gdad_pkg::MONTH_JAN;
          state_nxt = gdad_pkg::ST_WALK;
        end
      end
      gdad_pkg::ST_WALK: begin
        // take off one month per cycle until the rest fits
        alu_sub = 1'b1;
        if (fits_month) begin
          state_nxt = gdad_pkg::ST_DONE;
        end else begin
          total_nxt = alu_out;
          if (month_r == gdad_pkg::MONTH_DEC) begin
            month_nxt    = gdad_pkg::MONTH_JAN;
            year_ctl.inc = 1'b1;
          end else begin
            month_nxt = month_r + 1'b1;
          end
        end
      end
      gdad_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, total_r[gdad_pkg::DAY_W-1:0], month_r, year};
          state_nxt     = gdad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gdad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    month_r    <= month_nxt;
    smonth_r   <= smonth_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == gdad_pkg::ST_DIV)
    else $error("accepted item did not start the year division");
  a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gdad_pkg::ST_WALK |-> (month_r >= gdad_pkg::MONTH_JAN &&
                                      month_r <= gdad_pkg::MONTH_DEC))
    else $error("month walk left the range of months");
  a_walk_leap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdad_pkg::ST_WALK || state_r == gdad_pkg::ST_PREFIX) |-> !year_stat.busy)
    else $error("leap flag used while year division runs");
  a_done_day: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gdad_pkg::ST_DONE |-> total_r < gdad_pkg::TOTAL_W'(32))
    else $error("day remainder too large for a month");
`endif

endmodule

`default_nettype wire
